/* rtl/gss_pkg.sv */
// Shared types and constants of the glyph strip column segmenter.
package gss_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegImageWidth     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegImageHeight    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFirstCharacter = 2'd2;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StFlush
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic scan_start;
    logic scan;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } stat_t;

endpackage

/* rtl/gss_ctrl.sv */
// Controller state machine: pixel intake, column scan and final result.
module gss_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic           image_end_i,
  input  gss_pkg::stat_t stat_i,
  output gss_pkg::cmd_t  cmd_o,
  output logic           busy
);

  gss_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gss_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    busy             = 1'b1;
    unique case (state_q)
      gss_pkg::StIdle: begin
        busy       = 1'b0;
        cmd_o.take = start;
        if (start && image_end_i) begin
          cmd_o.scan_start = 1'b1;
          state_d          = gss_pkg::StScan;
        end
      end
      gss_pkg::StScan: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = gss_pkg::StFlush;
        end
      end
      gss_pkg::StFlush: begin
        cmd_o.flush = 1'b1;
        state_d     = gss_pkg::StIdle;
      end
      default: begin
        state_d = gss_pkg::StIdle;
      end
    endcase
  end

endmodule

/* rtl/gss_dp.sv */
// Datapath: configuration, column occupancy, run detection and result registers.
module gss_dp #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gss_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic [31:0]                  pixel_color_i,
  input  gss_pkg::cmd_t                cmd_i,
  output gss_pkg::stat_t               stat_o,
  output logic                         strobe_o,
  output logic [6:0]                   glyph_x_o,
  output logic [7:0]                   glyph_width_o,
  output logic [10:0]                  glyph_height_o,
  output logic [15:0]                  char_code_o,
  output logic                         status_o,
  output logic                         run_last_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam logic [10:0] MaxHeightField = 11'(MAX_HEIGHT);

  logic [7:0]  width_q;
  logic [10:0] height_q;
  logic [15:0] first_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 8'd1;
      height_q <= 11'd1;
      first_q  <= 16'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gss_pkg::RegImageWidth:     width_q  <= cfg_data_i[7:0];
        gss_pkg::RegImageHeight:    height_q <= cfg_data_i[10:0];
        gss_pkg::RegFirstCharacter: first_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [WW-1:0] eff_w;
  logic [10:0]   eff_h;

  always_comb begin
    if (width_q == 8'd0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == 11'd0) begin
      eff_h = 11'd1;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = MaxHeightField;
    end else begin
      eff_h = height_q;
    end
  end

  // Pixel intake. The first pixel of an image compares against itself.
  logic [31:0]          border_q;
  logic                 open_q;
  logic [CW-1:0]        col_q, col_d;
  logic [MAX_WIDTH-1:0] occ_q;
  logic [31:0]          border_cur;

  assign border_cur = open_q ? border_q : pixel_color_i;

  always_comb begin
    if ((WW'(col_q) + WW'(1)) >= eff_w) begin
      col_d = '0;
    end else begin
      col_d = col_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && !open_q) begin
      border_q <= pixel_color_i;
    end
  end

  // During the scan the occupancy vector shifts right, so bit 0 always holds
  // the column under the scan counter.
  logic [WW-1:0] scan_q;
  logic          occ_now;
  logic          run_open_q;
  logic          close_run;
  logic          emit_scan;

  assign occ_now   = (scan_q < eff_w) && occ_q[0];
  assign close_run = cmd_i.scan && !occ_now && run_open_q;
  assign stat_o.scan_done = (scan_q == eff_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      col_q  <= '0;
      occ_q  <= '0;
    end else if (cmd_i.flush) begin
      open_q <= 1'b0;
      col_q  <= '0;
      occ_q  <= '0;
    end else if (cmd_i.take) begin
      open_q <= 1'b1;
      col_q  <= col_d;
      if (pixel_color_i != border_cur) begin
        occ_q[col_q] <= 1'b1;
      end
    end else if (cmd_i.scan) begin
      occ_q <= occ_q >> 1;
    end
  end

  // Run tracking with one pending result, so that the last one can be marked.
  logic [WW-1:0] run_start_q;
  logic          pend_v_q;
  logic [6:0]    pend_x_q;
  logic [7:0]    pend_w_q;
  logic [15:0]   pend_code_q;
  logic [6:0]    gcount_q;

  assign emit_scan = close_run && pend_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      run_open_q <= 1'b0;
      pend_v_q   <= 1'b0;
      gcount_q   <= '0;
    end else if (cmd_i.scan_start) begin
      scan_q     <= '0;
      run_open_q <= 1'b0;
      pend_v_q   <= 1'b0;
      gcount_q   <= '0;
    end else if (cmd_i.scan) begin
      scan_q <= scan_q + WW'(1);
      if (occ_now && !run_open_q) begin
        run_open_q <= 1'b1;
      end else if (close_run) begin
        run_open_q <= 1'b0;
        pend_v_q   <= 1'b1;
        gcount_q   <= gcount_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && occ_now && !run_open_q) begin
      run_start_q <= scan_q;
    end
    if (close_run) begin
      pend_x_q    <= 7'(run_start_q);
      pend_w_q    <= 8'(scan_q - run_start_q);
      pend_code_q <= first_q + 16'(gcount_q);
    end
  end

  // Result registers.
  logic        strobe_q;
  logic        last_q;
  logic        status_q;
  logic [6:0]  x_q;
  logic [7:0]  w_q;
  logic [10:0] h_q;
  logic [15:0] code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
      last_q   <= 1'b0;
      status_q <= 1'b0;
    end else begin
      strobe_q <= emit_scan || cmd_i.flush;
      last_q   <= cmd_i.flush;
      status_q <= cmd_i.flush && !pend_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_scan || (cmd_i.flush && pend_v_q)) begin
      x_q    <= pend_x_q;
      w_q    <= pend_w_q;
      h_q    <= eff_h;
      code_q <= pend_code_q;
    end else if (cmd_i.flush) begin
      x_q    <= '0;
      w_q    <= '0;
      h_q    <= '0;
      code_q <= '0;
    end
  end

  assign strobe_o       = strobe_q;
  assign run_last_o     = last_q;
  assign status_o       = status_q;
  assign glyph_x_o      = x_q;
  assign glyph_width_o  = w_q;
  assign glyph_height_o = h_q;
  assign char_code_o    = code_q;

  // A result only follows a scan or flush cycle.
  a_strobe_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(cmd_i.scan || cmd_i.flush))
    else $error("result strobe without scan or flush");

  // The final-result flag always rides on a strobe.
  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> strobe_q)
    else $error("run_last without strobe");

  // The occupancy store is empty once an image is finished.
  a_occ_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |=> (occ_q == '0) && !open_q)
    else $error("occupancy not cleared after image");

  // The scan never runs past the image width.
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan |-> (scan_q <= eff_w))
    else $error("scan counter beyond width");

endmodule

/* rtl/glyph_strip_column_segmenter.sv */
// Glyph strip column segmenter: top level joining controller and datapath.
//
// Pixels are taken one per cycle while busy is low. The pixel that carries
// image_end starts the column scan, during which busy stays high: the scan
// reads one column of the occupancy store per cycle over width plus one
// steps, and the flush state after it delivers the final result. Each result
// is shown for one cycle with strobe_o high and cannot be held off; results
// of one image come at most one per cycle, in column order, the last one
// marked by run_last_o. Pixels that do not end an image produce no result.
module glyph_strip_column_segmenter #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gss_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         start,
  output logic                         busy,
  input  logic [31:0]                  pixel_color_i,
  input  logic                         image_end_i,
  output logic                         strobe_o,
  output logic [6:0]                   glyph_x_o,
  output logic [7:0]                   glyph_width_o,
  output logic [10:0]                  glyph_height_o,
  output logic [15:0]                  char_code_o,
  output logic                         status_o,
  output logic                         run_last_o
);

  gss_pkg::cmd_t  cmd;
  gss_pkg::stat_t stat;

  gss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .image_end_i (image_end_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  gss_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_color_i  (pixel_color_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .strobe_o       (strobe_o),
    .glyph_x_o      (glyph_x_o),
    .glyph_width_o  (glyph_width_o),
    .glyph_height_o (glyph_height_o),
    .char_code_o    (char_code_o),
    .status_o       (status_o),
    .run_last_o     (run_last_o)
  );

endmodule
